>>> src/bsr_pkg.sv
// shared types and constants of the stream registry
package bsr_pkg;
	localparam int DEPTH = 32;
	localparam int SLOTS = DEPTH + 1;
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam int CW = 6;

	localparam logic [1:0] CMD_ACQUIRE  = 2'd0;
	localparam logic [1:0] CMD_SWEEP    = 2'd1;
	localparam logic [1:0] CMD_CLEAR    = 2'd2;
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	localparam logic [2:0] OC_ALIAS   = 3'd0;
	localparam logic [2:0] OC_UPLOAD  = 3'd1;
	localparam logic [2:0] OC_EVICTED = 3'd2;
	localparam logic [2:0] OC_DROPPED = 3'd3;
	localparam logic [2:0] OC_DONE    = 3'd4;
	localparam logic [2:0] OC_CLEARED = 3'd5;

	typedef struct packed {
		logic [3:0]  kind;
		logic [4:0]  location;
		logic [2:0]  components;
		logic [47:0] buffer;
		logic [31:0] revision;
		logic [31:0] offset;
		logic [31:0] count;
	} key_t;

	typedef struct packed {
		key_t        key;
		logic [31:0] seen_frame;
	} entry_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  key_kind;
		logic [4:0]  key_location;
		logic [2:0]  key_components;
		logic [47:0] key_buffer;
		logic [31:0] key_revision;
		logic [31:0] key_offset;
		logic [31:0] key_count;
		logic [31:0] frame_number;
		logic [31:0] grace_frames;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [3:0]  out_kind;
		logic [4:0]  out_location;
		logic [2:0]  out_components;
		logic [47:0] out_buffer;
		logic [31:0] out_revision;
		logic [31:0] out_offset;
		logic [31:0] out_count;
		logic [5:0]  released;
		logic [5:0]  live_entries;
		logic        last;
	} out_item_t;
endpackage

>>> src/bounded_stream_registry_with_aging.sv
// Registry of up to 32 stream keys in one memory, kept in insertion order. Every walk
// of the store goes through the single read port: an acquire scans the live entries,
// then moves entries down after an eviction; a sweep makes a counting walk, then a
// compacting walk; a clear does not walk the store. Stalls on the result channel can
// lengthen any command. Capacity is to be written through the cfg port only while idle;
// the block itself does not enforce this. 0 acts as 1 and values above 32 act as 32.
module bounded_stream_registry_with_aging import bsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [CW-1:0] cfg_data,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_SCAN_RD = 13'b0000000000010,
		S_SCAN_EV = 13'b0000000000100,
		S_APPEND  = 13'b0000000001000,
		S_EVICT   = 13'b0000000010000,
		S_MOVE_RD = 13'b0000000100000,
		S_MOVE_EV = 13'b0000001000000,
		S_CNT_RD  = 13'b0000010000000,
		S_CNT_EV  = 13'b0000100000000,
		S_SW_RD   = 13'b0001000000000,
		S_SW_EV   = 13'b0010000000000,
		S_SW_DONE = 13'b0100000000000,
		S_CLEAR   = 13'b1000000000000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cap_q;
	logic [LW-1:0]   live_q;
	logic [LW-1:0]   idx_q;
	logic [LW-1:0]   wr_q;
	logic [LW-1:0]   cnt_q;
	in_item_t        req_q;
	logic [31:0]     min_lf_q;
	logic [LW-1:0]   min_idx_q;
	key_t            min_key_q;
	logic [LW-1:0]   ev_idx_q;
	key_t            ev_key_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	entry_t          ram_wdata;
	entry_t          rd_data;

	logic            emit_req;
	logic            emit_ready;
	logic            fire;
	out_item_t       emit_item;

	key_t            req_key;
	logic [LW-1:0]   eff_cap;
	logic            evict;
	logic            new_is_min;
	logic            match;
	logic            drop;
	logic            last_idx;
	logic [LW-1:0]   live_after_sweep;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE);

	assign req_key = '{kind: req_q.key_kind, location: req_q.key_location,
		components: req_q.key_components, buffer: req_q.key_buffer,
		revision: req_q.key_revision, offset: req_q.key_offset, count: req_q.key_count};

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = LW'(1);
		end else if (cap_q > CW'(DEPTH)) begin
			eff_cap = LW'(DEPTH);
		end else begin
			eff_cap = LW'(cap_q);
		end
	end

	// appending one entry pushes the count past capacity
	assign evict = (live_q >= eff_cap);
	assign new_is_min = (live_q == '0) || (req_q.frame_number < min_lf_q);
	assign match = (rd_data.key == req_key);
	// saturating age compared to grace
	assign drop = (req_q.frame_number >= rd_data.seen_frame) &&
		((req_q.frame_number - rd_data.seen_frame) > req_q.grace_frames);
	assign last_idx = (LW'(idx_q + 1'b1) == live_q);
	assign live_after_sweep = live_q - cnt_q;

	bsr_ram #(.WIDTH($bits(entry_t)), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	bsr_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (emit_req),
		.load_ready (emit_ready),
		.load_item  (emit_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

	assign fire = emit_req && emit_ready;

	always_comb begin
		emit_req = 1'b0;
		emit_item = '0;
		ram_we = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = rd_data;
		case (state_q)
			S_SCAN_EV: begin
				if (match) begin
					emit_req = 1'b1;
					emit_item.outcome = OC_ALIAS;
					emit_item.live_entries = 6'(live_q);
					emit_item.last = 1'b1;
					ram_we = fire;
					ram_wdata = '{key: req_key, seen_frame: req_q.frame_number};
				end
			end
			S_APPEND: begin
				emit_req = 1'b1;
				emit_item.outcome = OC_UPLOAD;
				emit_item.live_entries = evict ? 6'(live_q) : 6'(LW'(live_q + 1'b1));
				emit_item.last = !evict;
				ram_we = fire;
				ram_waddr = live_q[AW-1:0];
				ram_wdata = '{key: req_key, seen_frame: req_q.frame_number};
			end
			S_EVICT: begin
				emit_req = 1'b1;
				emit_item.outcome = OC_EVICTED;
				emit_item.out_kind = ev_key_q.kind;
				emit_item.out_location = ev_key_q.location;
				emit_item.out_components = ev_key_q.components;
				emit_item.out_buffer = ev_key_q.buffer;
				emit_item.out_revision = ev_key_q.revision;
				emit_item.out_offset = ev_key_q.offset;
				emit_item.out_count = ev_key_q.count;
				emit_item.live_entries = 6'(live_q);
				emit_item.last = 1'b1;
			end
			S_MOVE_EV: begin
				ram_we = 1'b1;
				ram_waddr = wr_q[AW-1:0];
			end
			S_SW_EV: begin
				if (drop) begin
					emit_req = 1'b1;
					emit_item.outcome = OC_DROPPED;
					emit_item.out_kind = rd_data.key.kind;
					emit_item.out_location = rd_data.key.location;
					emit_item.out_components = rd_data.key.components;
					emit_item.out_buffer = rd_data.key.buffer;
					emit_item.out_revision = rd_data.key.revision;
					emit_item.out_offset = rd_data.key.offset;
					emit_item.out_count = rd_data.key.count;
					emit_item.live_entries = 6'(live_after_sweep);
				end else begin
					ram_we = 1'b1;
					ram_waddr = wr_q[AW-1:0];
				end
			end
			S_SW_DONE: begin
				emit_req = 1'b1;
				emit_item.outcome = OC_DONE;
				emit_item.released = 6'(cnt_q);
				emit_item.live_entries = 6'(live_after_sweep);
				emit_item.last = 1'b1;
			end
			S_CLEAR: begin
				emit_req = 1'b1;
				emit_item.outcome = OC_CLEARED;
				emit_item.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q <= CW'(32);
			live_q <= '0;
			idx_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					wr_q <= '0;
					cnt_q <= '0;
					if (in_valid) begin
						case (in_item.cmd)
							CMD_ACQUIRE: state_q <= (live_q == '0) ? S_APPEND : S_SCAN_RD;
							CMD_SWEEP:   state_q <= (live_q == '0) ? S_SW_DONE : S_CNT_RD;
							CMD_CLEAR:   state_q <= S_CLEAR;
							default:     state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					if (match) begin
						if (fire) begin
							state_q <= S_IDLE;
						end
					end else if (last_idx) begin
						state_q <= S_APPEND;
					end else begin
						idx_q <= LW'(idx_q + 1'b1);
						state_q <= S_SCAN_RD;
					end
				end
				S_APPEND: begin
					if (fire) begin
						if (evict) begin
							state_q <= S_EVICT;
						end else begin
							live_q <= LW'(live_q + 1'b1);
							state_q <= S_IDLE;
						end
					end
				end
				S_EVICT: begin
					if (fire) begin
						if (ev_idx_q == live_q) begin
							state_q <= S_IDLE;
						end else begin
							// close the gap: entries above the victim move down one
							idx_q <= LW'(ev_idx_q + 1'b1);
							wr_q <= ev_idx_q;
							state_q <= S_MOVE_RD;
						end
					end
				end
				S_MOVE_RD: state_q <= S_MOVE_EV;
				S_MOVE_EV: begin
					if (idx_q == live_q) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= LW'(idx_q + 1'b1);
						wr_q <= LW'(wr_q + 1'b1);
						state_q <= S_MOVE_RD;
					end
				end
				S_CNT_RD: state_q <= S_CNT_EV;
				S_CNT_EV: begin
					if (drop) begin
						cnt_q <= LW'(cnt_q + 1'b1);
					end
					if (last_idx) begin
						idx_q <= '0;
						state_q <= S_SW_RD;
					end else begin
						idx_q <= LW'(idx_q + 1'b1);
						state_q <= S_CNT_RD;
					end
				end
				S_SW_RD: state_q <= S_SW_EV;
				S_SW_EV: begin
					if (!drop || fire) begin
						if (!drop) begin
							wr_q <= LW'(wr_q + 1'b1);
						end
						if (last_idx) begin
							state_q <= S_SW_DONE;
						end else begin
							idx_q <= LW'(idx_q + 1'b1);
							state_q <= S_SW_RD;
						end
					end
				end
				S_SW_DONE: begin
					if (fire) begin
						live_q <= live_after_sweep;
						state_q <= S_IDLE;
					end
				end
				S_CLEAR: begin
					if (fire) begin
						live_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_item;
		end
		// stalest entry so far, earliest slot wins ties
		if (state_q == S_SCAN_EV && !match &&
			(idx_q == '0 || rd_data.seen_frame < min_lf_q)) begin
			min_lf_q <= rd_data.seen_frame;
			min_idx_q <= idx_q;
			min_key_q <= rd_data.key;
		end
		if (state_q == S_APPEND) begin
			ev_idx_q <= new_is_min ? live_q : min_idx_q;
			ev_key_q <= new_is_min ? req_key : min_key_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= LW'(DEPTH))
		else $error("live count above depth");

	a_alias_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.outcome == OC_ALIAS |-> out_item.last)
		else $error("alias result not final");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.outcome == OC_CLEARED |->
		out_item.live_entries == '0 && live_q == '0)
		else $error("clear left entries");
`endif
endmodule

>>> src/bsr_ram.sv
// generic simple dual-port ram with registered read
module bsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/bsr_outbuf.sv
// output register between the sequencer and the result channel
module bsr_outbuf import bsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load_valid,
	output logic      load_ready,
	input  out_item_t load_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	logic      valid_q;
	out_item_t item_q;

	assign load_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			item_q <= load_item;
		end
	end
endmodule
